### rtl/lpe_pkg.sv
// ----------------------------------------------------------------------------
// lpe_pkg: shared types and constants for the LPC prediction error engine
// Widths, item layouts, state encodings and the prediction saturation.
// ----------------------------------------------------------------------------
package lpe_pkg;

    localparam int ORDER     = 64;
    localparam int FRAC_BITS = 12;

    localparam int TAP_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int CNT_W  = $clog2(ORDER + 1);

    localparam int IDX_W  = 6;
    localparam int COEF_W = 20;
    localparam int SMP_W  = 16;
    localparam int OUT_W  = 32;
    localparam int SUM_W  = 48;
    localparam int PROD_W = COEF_W + SMP_W;
    localparam int ACC_W  = PROD_W + CNT_W;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = OUT_W + OUT_W + SUM_W;

    localparam int Q_DEPTH = 2;
    localparam int QP_W    = 1;

    localparam logic signed [63:0] PRED_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] PRED_MIN = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

    typedef enum logic [0:0] {
        ACT_LOAD   = 1'b0,
        ACT_SAMPLE = 1'b1
    } action_t;

    typedef struct packed {
        action_t                  action;
        logic [TAP_W-1:0]         tap;
        logic signed [COEF_W-1:0] coef;
        logic signed [SMP_W-1:0]  smp;
        logic                     measure;
        logic                     end_window;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MAC,
        BK_DRAIN,
        BK_PRED,
        BK_RES,
        BK_SUM,
        BK_OUT
    } bk_state_t;

    // Saturate the shifted accumulator to the signed 32-bit range.
    function automatic logic signed [OUT_W-1:0] sat_pred(input logic signed [ACC_W-1:0] x);
        logic signed [63:0] w;
        w = 64'(x);
        if (w > PRED_MAX) begin
            return OUT_MAX;
        end else if (w < PRED_MIN) begin
            return OUT_MIN;
        end
        return w[OUT_W-1:0];
    endfunction

endpackage

### rtl/lpe_front.sv
// ----------------------------------------------------------------------------
// lpe_front: input item decode and classification
// Unpacks the stream item, drops loads to taps beyond the order, and pushes
// the rest into the command queue.
// ----------------------------------------------------------------------------
module lpe_front (
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lpe_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  logic                         s_tlast,
    input  logic                         q_full,
    output lpe_pkg::q_push_t             q_push
);

    logic [lpe_pkg::IDX_W-1:0] coef_index;
    logic                      tap_ok;
    lpe_pkg::cmd_t             cmd;

    assign coef_index = s_tdata[lpe_pkg::IDX_W-1:0];
    assign tap_ok     = (32'(coef_index) < 32'(lpe_pkg::ORDER));

    always_comb begin
        cmd.action     = lpe_pkg::action_t'(s_tuser);
        cmd.tap        = lpe_pkg::TAP_W'(coef_index);
        cmd.coef       = s_tdata[25:6];
        cmd.smp        = s_tdata[41:26];
        cmd.measure    = s_tdata[42];
        cmd.end_window = s_tlast;
    end

    assign s_tready = aresetn && !q_full;

    // Drop loads aimed past the last tap; they have no effect.
    assign q_push.push = s_tvalid && s_tready &&
                         ((cmd.action == lpe_pkg::ACT_SAMPLE) || tap_ok);
    assign q_push.cmd  = cmd;

endmodule

### rtl/lpe_queue.sv
// ----------------------------------------------------------------------------
// lpe_queue: command queue between front and back end
// Two-entry FIFO of decoded commands.
// ----------------------------------------------------------------------------
module lpe_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  lpe_pkg::q_push_t q_push,
    output logic             q_full,
    input  logic             q_pop,
    output lpe_pkg::q_head_t q_head
);

    lpe_pkg::cmd_t              entry_reg [lpe_pkg::Q_DEPTH];
    logic [lpe_pkg::QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lpe_pkg::QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lpe_pkg::QP_W:0]     count_reg, count_next;
    logic                       do_pop;

    assign q_full       = (count_reg == (lpe_pkg::QP_W + 1)'(lpe_pkg::Q_DEPTH));
    assign q_head.valid = (count_reg != '0);
    assign q_head.cmd   = entry_reg[rd_ptr_reg];
    assign do_pop       = q_pop && q_head.valid;

    always_comb begin
        wr_ptr_next = q_push.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!q_push.push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.push) begin
            entry_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/lpe_back.sv
// ----------------------------------------------------------------------------
// lpe_back: coefficient store, history ring and multiply-accumulate sequencer
// Executes loads, runs one tap per cycle for a sample, finishes the
// prediction, residual and error sum, and holds the result item.
// ----------------------------------------------------------------------------
module lpe_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lpe_pkg::q_head_t             q_head,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lpe_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);

    localparam logic [lpe_pkg::TAP_W-1:0] LAST_TAP  = lpe_pkg::TAP_W'(lpe_pkg::ORDER - 1);
    localparam logic [lpe_pkg::CNT_W-1:0] LAST_CNT  = lpe_pkg::CNT_W'(lpe_pkg::ORDER - 1);
    localparam logic [lpe_pkg::CNT_W-1:0] FULL_CNT  = lpe_pkg::CNT_W'(lpe_pkg::ORDER);

    lpe_pkg::bk_state_t state_reg, state_next;

    logic do_load, start, issue, commit, out_free;

    // storage
    logic [lpe_pkg::COEF_W-1:0] coef_mem [lpe_pkg::ORDER];
    logic [lpe_pkg::SMP_W-1:0]  hist_mem [lpe_pkg::ORDER];
    logic [lpe_pkg::ORDER-1:0]  coef_vld_reg;

    // sequencing
    lpe_pkg::cmd_t              cur_reg;
    logic [lpe_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [lpe_pkg::TAP_W-1:0]  hrd_reg, hrd_next;
    logic [lpe_pkg::TAP_W-1:0]  wp_reg, wp_next;
    logic [lpe_pkg::CNT_W-1:0]  fill_reg, fill_next;

    // MAC pipeline
    logic [lpe_pkg::COEF_W-1:0]        coef_rd_reg;
    logic [lpe_pkg::SMP_W-1:0]         hist_rd_reg;
    logic                              coef_ok_reg, hist_ok_reg;
    logic                              p1_reg, p2_reg;
    logic signed [lpe_pkg::COEF_W-1:0] coef_op;
    logic signed [lpe_pkg::SMP_W-1:0]  hist_op;
    logic signed [lpe_pkg::PROD_W-1:0] prod_reg;
    logic signed [lpe_pkg::ACC_W-1:0]  acc_reg;

    // finish
    logic signed [lpe_pkg::OUT_W-1:0]  pred_reg, res_reg;
    logic signed [lpe_pkg::OUT_W:0]    diff;
    logic [lpe_pkg::OUT_W-1:0]         mag;
    logic [lpe_pkg::SUM_W:0]           wide_sum;
    logic [lpe_pkg::SUM_W-1:0]         sum_reg, err_reg;

    // result
    logic                              out_vld_reg;
    logic [lpe_pkg::M_DATA_W-1:0]      out_data_reg;
    logic                              out_last_reg;

    assign out_free = !out_vld_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpe_pkg::BK_IDLE: begin
                if (q_head.valid && (q_head.cmd.action == lpe_pkg::ACT_SAMPLE)) begin
                    state_next = lpe_pkg::BK_MAC;
                end
            end
            lpe_pkg::BK_MAC: begin
                if (cnt_reg == LAST_CNT) begin
                    state_next = lpe_pkg::BK_DRAIN;
                end
            end
            lpe_pkg::BK_DRAIN: begin
                if (!p1_reg && !p2_reg) begin
                    state_next = lpe_pkg::BK_PRED;
                end
            end
            lpe_pkg::BK_PRED: state_next = lpe_pkg::BK_RES;
            lpe_pkg::BK_RES:  state_next = lpe_pkg::BK_SUM;
            lpe_pkg::BK_SUM:  state_next = lpe_pkg::BK_OUT;
            lpe_pkg::BK_OUT: begin
                if (out_free) begin
                    state_next = lpe_pkg::BK_IDLE;
                end
            end
            default: state_next = lpe_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        q_pop   = 1'b0;
        do_load = 1'b0;
        start   = 1'b0;
        issue   = 1'b0;
        commit  = 1'b0;
        case (state_reg)
            lpe_pkg::BK_IDLE: begin
                q_pop   = q_head.valid;
                do_load = q_head.valid && (q_head.cmd.action == lpe_pkg::ACT_LOAD);
                start   = q_head.valid && (q_head.cmd.action == lpe_pkg::ACT_SAMPLE);
            end
            lpe_pkg::BK_MAC: issue  = 1'b1;
            lpe_pkg::BK_OUT: commit = out_free;
            default: ;
        endcase
    end

    // tap counter and ring pointers
    always_comb begin
        cnt_next  = cnt_reg;
        hrd_next  = hrd_reg;
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (start) begin
            cnt_next = '0;
            hrd_next = (wp_reg == '0) ? LAST_TAP : wp_reg - 1'b1;
        end else if (issue) begin
            cnt_next = cnt_reg + 1'b1;
            hrd_next = (hrd_reg == '0) ? LAST_TAP : hrd_reg - 1'b1;
        end
        if (commit) begin
            wp_next = (wp_reg == LAST_TAP) ? '0 : wp_reg + 1'b1;
            if (fill_reg != FULL_CNT) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (do_load) begin
            coef_mem[q_head.cmd.tap] <= q_head.cmd.coef;
        end
        if (issue) begin
            coef_rd_reg <= coef_mem[cnt_reg[lpe_pkg::TAP_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            hist_mem[wp_reg] <= cur_reg.smp;
        end
        if (issue) begin
            hist_rd_reg <= hist_mem[hrd_reg];
        end
    end

    // zero unwritten entries
    assign coef_op = coef_ok_reg ? $signed(coef_rd_reg) : '0;
    assign hist_op = hist_ok_reg ? $signed(hist_rd_reg) : '0;

    assign diff = (lpe_pkg::OUT_W + 1)'($signed(cur_reg.smp)) -
                  (lpe_pkg::OUT_W + 1)'(pred_reg);
    assign mag  = res_reg[lpe_pkg::OUT_W-1] ? lpe_pkg::OUT_W'(-res_reg) : res_reg;
    assign wide_sum = {1'b0, err_reg} + (lpe_pkg::SUM_W + 1)'(mag);

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            cur_reg <= q_head.cmd;
        end
        if (issue) begin
            coef_ok_reg <= coef_vld_reg[cnt_reg[lpe_pkg::TAP_W-1:0]];
            hist_ok_reg <= (cnt_reg < fill_reg);
        end
        if (p1_reg) begin
            prod_reg <= lpe_pkg::PROD_W'(coef_op) * lpe_pkg::PROD_W'(hist_op);
        end
        if (start) begin
            acc_reg <= '0;
        end else if (p2_reg) begin
            acc_reg <= acc_reg + lpe_pkg::ACC_W'(prod_reg);
        end
        if (state_reg == lpe_pkg::BK_PRED) begin
            pred_reg <= lpe_pkg::sat_pred(acc_reg >>> lpe_pkg::FRAC_BITS);
        end
        if (state_reg == lpe_pkg::BK_RES) begin
            if (diff[lpe_pkg::OUT_W] != diff[lpe_pkg::OUT_W-1]) begin
                res_reg <= diff[lpe_pkg::OUT_W] ? lpe_pkg::OUT_MIN : lpe_pkg::OUT_MAX;
            end else begin
                res_reg <= diff[lpe_pkg::OUT_W-1:0];
            end
        end
        if (state_reg == lpe_pkg::BK_SUM) begin
            if (!cur_reg.measure) begin
                sum_reg <= err_reg;
            end else if (wide_sum[lpe_pkg::SUM_W]) begin
                sum_reg <= '1;
            end else begin
                sum_reg <= wide_sum[lpe_pkg::SUM_W-1:0];
            end
        end
        if (commit) begin
            out_data_reg <= {sum_reg, res_reg, pred_reg};
            out_last_reg <= cur_reg.end_window;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lpe_pkg::BK_IDLE;
            cnt_reg      <= '0;
            hrd_reg      <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            coef_vld_reg <= '0;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            err_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hrd_reg   <= hrd_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            p1_reg    <= issue;
            p2_reg    <= p1_reg;
            if (do_load) begin
                coef_vld_reg[q_head.cmd.tap] <= 1'b1;
            end
            if (commit) begin
                err_reg     <= cur_reg.end_window ? '0 : sum_reg;
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/lpc_prediction_error.sv
// ----------------------------------------------------------------------------
// lpc_prediction_error: linear-prediction residual engine
// Predicts each sample from the previous ORDER samples, emits prediction,
// residual and a windowed saturating sum of absolute residuals of measured samples.
// ----------------------------------------------------------------------------
// Loads: a load item passes through the command queue and is written to the
//   tap store when the back end is idle.
// Throughput: the back end runs one sample item at a time, set by the single
//   multiply-accumulate unit that takes one tap per cycle; loads are taken
//   one per cycle while the back end is idle and not running a sample.
// Reset: synchronous, active low; coefficients, history and the error sum
//   read as zero right after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module lpc_prediction_error (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [5:0] coef_index, [25:6] coef_value, [41:26] sample, [42] measure,
    // [47:43] zero
    input  logic [lpe_pkg::S_DATA_W-1:0] s_tdata,
    // [0] action: 0 = load coefficient, 1 = process sample
    input  logic                         s_tuser,
    // end_window
    input  logic                         s_tlast,
    // result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] prediction, [63:32] residual, [111:64] error_sum
    output logic [lpe_pkg::M_DATA_W-1:0] m_tdata,
    // window_done
    output logic                         m_tlast
);

    lpe_pkg::q_push_t q_push;
    lpe_pkg::q_head_t q_head;
    logic             q_full;
    logic             q_pop;

    // Front end: decode the item, drop loads past the last tap, queue the rest.
    lpe_front u_front (
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push)
    );

    // Two-entry queue: hold decoded items while the back end runs a sample.
    lpe_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_head  (q_head)
    );

    // Back end: write coefficients, advance the MAC over all taps, finish the
    // prediction, residual and error sum, then hold the result in the
    // output register until it is taken.
    lpe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/lpe_checker.sv
// ----------------------------------------------------------------------------
// lpe_checker: port-level assertions for the prediction error engine
// Watches the result channel for reset, hold and window-sum behavior.
// ----------------------------------------------------------------------------
module lpe_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [lpe_pkg::S_DATA_W-1:0] s_tdata,
    input logic                         s_tuser,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lpe_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tlast
);

    // Set after reset and after a window total is taken: the sum restarts.
    logic fresh_win_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_win_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            fresh_win_reg <= m_tlast;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled result dropped");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // First result of a window carries at most one absolute residual.
    a_window_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && fresh_win_reg |-> (m_tdata[111:96] == 16'h0000))
        else $error("error sum not cleared at window start");

endmodule

bind lpc_prediction_error lpe_checker u_lpe_checker (.*);
